// File: rtl/core/tcm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcm_pkg
// Shared widths, register indexes, mode codes and control types for the
// threshold and 4-connected cross morphology block.
// ----------------------------------------------------------------------------
package tcm_pkg;

	localparam int PIX_W  = 8;
	localparam int CFG_IW = 2;
	localparam int CFG_DW = 11;

	// configuration register indexes
	localparam logic [CFG_IW-1:0] REG_THRESHOLD = 2'd0;
	localparam logic [CFG_IW-1:0] REG_OP_MODE   = 2'd1;
	localparam logic [CFG_IW-1:0] REG_WIDTH     = 2'd2;
	localparam logic [CFG_IW-1:0] REG_HEIGHT    = 2'd3;

	// operation modes
	localparam logic [1:0] MODE_THRESH = 2'd0;
	localparam logic [1:0] MODE_EXPAND = 2'd1;
	localparam logic [1:0] MODE_SHRINK = 2'd2;

	localparam logic [PIX_W-1:0] PIX_WHITE = 8'hFF;
	localparam logic [PIX_W-1:0] PIX_BLACK = 8'h00;

	// line store word layout
	localparam int LS_NEWER = 0;
	localparam int LS_OLDER = 1;

	typedef struct packed {
		logic shift;
		logic clear;
	} cell_ctl_t;

endpackage
`default_nettype wire

// File: rtl/core/tcm_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcm_cell
// One binary window cell: takes its neighbor's bit on shift, clears on
// frame restart.
// ----------------------------------------------------------------------------
module tcm_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  tcm_pkg::cell_ctl_t ctl,
	input  logic               d,
	output logic               q
);
	import tcm_pkg::*;

	logic bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_q <= 1'b0;
		end else if (ctl.clear) begin
			bit_q <= 1'b0;
		end else if (ctl.shift) begin
			bit_q <= d;
		end
	end

	assign q = bit_q;

endmodule
`default_nettype wire

// File: rtl/core/tcm_line_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcm_line_store
// Two-bit-wide line memory holding the newer and older binary rows.
// Registered read, one write per cycle, same-cycle write forwarding, and a
// fill count so entries never written since reset read as zero.
// ----------------------------------------------------------------------------
module tcm_line_store #(
	parameter  int DEPTH = 1024,
	localparam int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [1:0]    rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [1:0]    wr_data
);
	import tcm_pkg::*;

	localparam int FW = $clog2(DEPTH + 1);

	logic [1:0]    mem [DEPTH];
	logic [1:0]    raw_q;
	logic [1:0]    fwd_data_q;
	logic          fwd_q;
	logic          known_q;
	logic [FW-1:0] fill_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			raw_q <= mem[rd_addr];
		end
	end

	// columns are always written in order from zero, so the written set is a prefix
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (wr_en && (FW'(wr_addr) == fill_q)) begin
			fill_q <= fill_q + FW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			fwd_q      <= wr_en && (wr_addr == rd_addr);
			fwd_data_q <= wr_data;
			known_q    <= FW'(rd_addr) < fill_q;
		end
	end

	assign rd_data = fwd_q ? fwd_data_q : (known_q ? raw_q : 2'b00);

endmodule
`default_nettype wire

// File: rtl/core/threshold_cross_morphology_unit.sv
`default_nettype none
// Result path: pixel p's result forms while the item bringing pixel
//   p + image_width + 1 (or the drain item in its place) sits in stage 1, and
//   goes to the output register. Throughput: one item per cycle unless a
//   stalled consumer holds stage 1; line store: one read, one write per cycle.
// Reset: registers return to their defaults, counters and window clear; line
//   store contents are kept, and entries not written since reset read as zero.
// ----------------------------------------------------------------------------
// threshold_cross_morphology_unit
// Thresholds a raster pixel stream and passes it on or applies a 4-connected
// cross expand or shrink using a line store and a row of window cells.
// ----------------------------------------------------------------------------
module threshold_cross_morphology_unit #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_write,
	input  logic [tcm_pkg::CFG_IW-1:0]  cfg_index,
	input  logic [tcm_pkg::CFG_DW-1:0]  cfg_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [tcm_pkg::PIX_W-1:0]   pixel_in,
	input  logic                        drain,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [tcm_pkg::PIX_W-1:0]   pixel_out,
	output logic                        last_pixel
);
	import tcm_pkg::*;

	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int HW    = $clog2(MAX_HEIGHT + 1);
	localparam int RW    = $clog2(MAX_HEIGHT + 2);
	localparam int ORW   = $clog2(MAX_HEIGHT);
	localparam int W_RST = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
	localparam int H_RST = (MAX_HEIGHT < 1024) ? MAX_HEIGHT : 1024;

	// configuration
	logic [PIX_W-1:0] thr_q;
	logic [1:0]       mode_q;
	logic [WW-1:0]    w_q;
	logic [HW-1:0]    h_q;
	logic             restart_cfg;

	// input side counters
	logic [CW-1:0]  col_q;
	logic [RW-1:0]  row_q;
	logic [CW-1:0]  ocol_q;
	logic [ORW-1:0] orow_q;

	// stage 1
	logic          v_s1;
	logic          bit_s1;
	logic [CW-1:0] col_s1;
	logic          emit_s1;
	logic          last_s1;
	logic          left_ok_s1;
	logic          right_ok_s1;
	logic          above_ok_s1;
	logic          below_ok_s1;

	// output register
	logic             out_valid_q;
	logic [PIX_W-1:0] pix_q;
	logic             last_q;

	logic          complete;
	logic          adv_item;
	logic          bit_in;
	logic [WW-1:0] col_inc;
	logic          wrap;
	logic          emit_in;
	logic [WW-1:0] ocol_inc;
	logic [HW-1:0] orow_inc;
	logic          owrap;
	logic          last_in;
	logic          take;
	logic          fire;

	logic [1:0] ls_rd;
	logic       right;
	logic       above;
	logic       centre;
	logic       left;
	logic       below;
	logic       any_white;
	logic       all_white;
	logic       res;

	cell_ctl_t win_ctl;

	assign restart_cfg = cfg_write && ((cfg_index == REG_WIDTH) || (cfg_index == REG_HEIGHT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q  <= PIX_W'(128);
			mode_q <= MODE_THRESH;
			w_q    <= WW'(W_RST);
			h_q    <= HW'(H_RST);
		end else if (cfg_write) begin
			case (cfg_index)
				REG_THRESHOLD: begin
					thr_q <= cfg_data[PIX_W-1:0];
				end
				REG_OP_MODE: begin
					mode_q <= cfg_data[1:0];
				end
				REG_WIDTH: begin
					if (cfg_data == '0) begin
						w_q <= WW'(1);
					end else if (int'(cfg_data) > MAX_WIDTH) begin
						w_q <= WW'(MAX_WIDTH);
					end else begin
						w_q <= WW'(cfg_data);
					end
				end
				REG_HEIGHT: begin
					if (cfg_data == '0) begin
						h_q <= HW'(1);
					end else if (int'(cfg_data) > MAX_HEIGHT) begin
						h_q <= HW'(MAX_HEIGHT);
					end else begin
						h_q <= HW'(cfg_data);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// classify the incoming item
	assign complete = row_q >= RW'(h_q);
	assign adv_item = complete || !drain;
	assign bit_in   = complete ? 1'b1 : (pixel_in > thr_q);
	assign col_inc  = WW'(col_q) + WW'(1);
	assign wrap     = col_inc == w_q;
	assign emit_in  = (row_q >= RW'(2)) || ((row_q == RW'(1)) && (col_q != '0));
	assign ocol_inc = WW'(ocol_q) + WW'(1);
	assign orow_inc = HW'(orow_q) + HW'(1);
	assign owrap    = ocol_inc == w_q;
	assign last_in  = owrap && (orow_inc == h_q);

	assign fire     = v_s1 && (!out_valid_q || out_ready);
	assign in_ready = !v_s1 || fire;
	assign take     = in_valid && in_ready && adv_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			ocol_q <= '0;
			orow_q <= '0;
		end else if (restart_cfg) begin
			col_q  <= '0;
			row_q  <= '0;
			ocol_q <= '0;
			orow_q <= '0;
		end else if (take) begin
			if (emit_in && last_in) begin
				col_q  <= '0;
				row_q  <= '0;
				ocol_q <= '0;
				orow_q <= '0;
			end else begin
				col_q <= wrap ? '0 : (col_q + CW'(1));
				if (wrap) begin
					row_q <= row_q + RW'(1);
				end
				if (emit_in) begin
					ocol_q <= owrap ? '0 : (ocol_q + CW'(1));
					if (owrap) begin
						orow_q <= orow_q + ORW'(1);
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (take) begin
			v_s1 <= 1'b1;
		end else if (fire) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			bit_s1      <= bit_in;
			col_s1      <= col_q;
			emit_s1     <= emit_in;
			last_s1     <= emit_in && last_in;
			left_ok_s1  <= ocol_q != '0;
			right_ok_s1 <= !owrap;
			above_ok_s1 <= orow_q != '0;
			below_ok_s1 <= orow_inc != h_q;
		end
	end

	tcm_line_store #(
		.DEPTH(MAX_WIDTH)
	) u_line_store (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (take),
		.rd_addr(col_q),
		.rd_data(ls_rd),
		.wr_en  (fire),
		.wr_addr(col_s1),
		.wr_data({centre, bit_s1})
	);

	assign right = ls_rd[LS_NEWER];
	assign above = ls_rd[LS_OLDER];

	// drop the window after the last result of a frame or on a size write
	assign win_ctl.shift = fire;
	assign win_ctl.clear = (fire && last_s1) || restart_cfg;

	tcm_cell u_cell_centre (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (win_ctl),
		.d     (right),
		.q     (centre)
	);

	tcm_cell u_cell_left (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (win_ctl),
		.d     (centre),
		.q     (left)
	);

	tcm_cell u_cell_below (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (win_ctl),
		.d     (bit_s1),
		.q     (below)
	);

	// neighbors outside the frame are ignored
	assign any_white = centre | (left_ok_s1 & left) | (right_ok_s1 & right)
		| (above_ok_s1 & above) | (below_ok_s1 & below);
	assign all_white = centre & (!left_ok_s1 | left) & (!right_ok_s1 | right)
		& (!above_ok_s1 | above) & (!below_ok_s1 | below);

	always_comb begin
		case (mode_q)
			MODE_EXPAND: res = all_white;
			MODE_SHRINK: res = any_white;
			default:     res = centre;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && emit_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && emit_s1) begin
			pix_q  <= res ? PIX_WHITE : PIX_BLACK;
			last_q <= last_s1;
		end
	end

	assign out_valid  = out_valid_q;
	assign pixel_out  = pix_q;
	assign last_pixel = last_q;

endmodule
`default_nettype wire

// File: rtl/core/tcm_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcm_checker
// Port-level checks for the threshold cross morphology unit, bound to the
// top level.
// ----------------------------------------------------------------------------
module tcm_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] pixel_out,
	input logic       last_pixel
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pixel_out) && $stable(last_pixel))
		else $error("result changed while stalled");

	a_out_binary: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pixel_out == 8'h00) || (pixel_out == 8'hFF))
		else $error("result pixel is not binary");

	// a fresh result follows an earlier input transfer
	a_out_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result without a matching input transfer");

	// with no result waiting the input side never stalls
	a_in_open: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

endmodule

bind threshold_cross_morphology_unit tcm_checker u_tcm_checker (.*);
`default_nettype wire

// File: tb/sv/threshold_cross_morphology_unit_tb.sv
// ----------------------------------------------------------------------------
// threshold_cross_morphology_unit_tb
// Drives raster pixel frames and flush drains through the threshold and
// 4-connected cross expand/shrink block under changing register settings and
// handshake pressure, and checks every output transfer against typed results
// or a cycle-free model of the line stores, window and frame counters.
// ----------------------------------------------------------------------------
module threshold_cross_morphology_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tcm_pkg::*;

	localparam int MAX_W         = 1024;
	localparam int MAX_H         = 1024;
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_CYCLES   = 400;
	localparam int ITEM_TARGET   = 1700;
	localparam int LIMIT_CYCLES  = 400000;
	localparam int N_DIRECTED    = 35;

	// mode code with no assigned meaning; the block treats it as threshold only
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	typedef struct packed {
		logic [PIX_W-1:0] pix;
		logic             last;
	} px_result_t;

	typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;
	typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_OUT} row_check_t;

	typedef struct packed {
		row_kind_t          kind;
		logic [CFG_IW-1:0]  idx;
		logic [CFG_DW-1:0]  val;
		logic [PIX_W-1:0]   pix;
		logic               drn;
		row_check_t         chk;
		px_result_t         res;
	} dir_row_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_write;
	logic [CFG_IW-1:0]  cfg_index;
	logic [CFG_DW-1:0]  cfg_data;
	logic               in_valid;
	logic               in_ready;
	logic [PIX_W-1:0]   pixel_in;
	logic               drain;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [PIX_W-1:0]   pixel_out;
	logic               last_pixel;

	threshold_cross_morphology_unit #(
		.MAX_WIDTH  (MAX_W),
		.MAX_HEIGHT (MAX_H)
	) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.pixel_in   (pixel_in),
		.drain      (drain),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.pixel_out  (pixel_out),
		.last_pixel (last_pixel)
	);

	always #5 clk = ~clk;

	// model state
	logic [PIX_W-1:0]  p_thresh = 8'd128;
	logic [1:0]        p_mode   = MODE_THRESH;
	logic [CFG_DW-1:0] p_width  = 11'd1024;
	logic [CFG_DW-1:0] p_height = 11'd1024;
	bit                above_bits  [MAX_W];
	bit                recent_bits [MAX_W];
	bit                win_new, win_mid, win_left;
	int unsigned       in_col, in_row, out_cnt;

	px_result_t        pending_px [$];
	int unsigned       mismatches = 0;
	int unsigned       cycle_cnt = 0;
	int                snd_pct = 0;
	int                rcv_pct = 0;
	bit                hold_go = 1'b0;
	int unsigned       hold_cnt = 0;

	function automatic int unsigned clamp_size(input int unsigned v, input int unsigned lim);
		if (v < 1) return 1;
		if (v > lim) return lim;
		return v;
	endfunction

	function automatic dir_row_t cfg_row(input logic [CFG_IW-1:0] idx,
		input logic [CFG_DW-1:0] val);
		dir_row_t r;
		r = '0;
		r.kind = ROW_CFG;
		r.idx = idx;
		r.val = val;
		return r;
	endfunction

	function automatic dir_row_t item_row(input logic [PIX_W-1:0] pix, input logic drn,
		input row_check_t chk, input logic [PIX_W-1:0] epix = PIX_BLACK,
		input logic elast = 1'b0);
		dir_row_t r;
		r = '0;
		r.kind = ROW_ITEM;
		r.pix = pix;
		r.drn = drn;
		r.chk = chk;
		r.res.pix = epix;
		r.res.last = elast;
		return r;
	endfunction

	task automatic restart_frame();
		win_new = 1'b0;
		win_mid = 1'b0;
		win_left = 1'b0;
		in_col = 0;
		in_row = 0;
		out_cnt = 0;
	endtask

	// Advance the window by one pixel slot; emits the result for the pixel
	// that sits width + 1 slots behind the newest one.
	task automatic crossmorph_step(input logic [PIX_W-1:0] pix, input logic drn,
		output bit got, output px_result_t res);
		int unsigned w, h, c, q, pc, pr;
		bit b, right, above, below, mid, left, any_w, all_w, r;
		w = clamp_size(p_width, MAX_W);
		h = clamp_size(p_height, MAX_H);
		got = 1'b0;
		res = '0;
		// drop a drain that arrives while the frame still lacks pixels
		if (in_row < h && drn)
			return;
		b = (in_row < h) ? (pix > p_thresh) : 1'b1;
		c = in_col % w;
		q = in_row * w + c;
		right = recent_bits[c];
		above = above_bits[c];
		below = win_new;
		mid = win_mid;
		left = win_left;
		above_bits[c] = mid;
		recent_bits[c] = b;
		win_left = mid;
		win_mid = right;
		win_new = b;
		in_col = c + 1;
		if (in_col >= w) begin
			in_col = 0;
			in_row++;
		end
		if (q >= w + 1) begin
			pc = out_cnt % w;
			pr = out_cnt / w;
			any_w = mid;
			all_w = mid;
			if (pc > 0) begin
				any_w |= left;
				all_w &= left;
			end
			if (pc + 1 < w) begin
				any_w |= right;
				all_w &= right;
			end
			if (pr > 0) begin
				any_w |= above;
				all_w &= above;
			end
			if (pr + 1 < h) begin
				any_w |= below;
				all_w &= below;
			end
			case (p_mode)
				MODE_EXPAND: r = all_w;
				MODE_SHRINK: r = any_w;
				default:     r = mid;
			endcase
			out_cnt++;
			res.pix = r ? PIX_WHITE : PIX_BLACK;
			res.last = (out_cnt >= w * h);
			if (res.last)
				restart_frame();
			got = 1'b1;
		end
	endtask

	// Leaves cfg_write high; the caller drops it after the last write.
	task automatic write_reg(input logic [CFG_IW-1:0] idx, input int unsigned val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[CFG_DW-1:0];
		case (idx)
			REG_THRESHOLD: p_thresh = val[PIX_W-1:0];
			REG_OP_MODE:   p_mode = val[1:0];
			REG_WIDTH: begin
				p_width = val[CFG_DW-1:0];
				restart_frame();
			end
			default: begin
				p_height = val[CFG_DW-1:0];
				restart_frame();
			end
		endcase
		@(negedge clk);
	endtask

	task automatic quiesce();
		in_valid <= 1'b0;
		while (pending_px.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_item(input logic [PIX_W-1:0] pix, input logic drn,
		input row_check_t chk, input px_result_t typed);
		px_result_t predicted;
		bit got;
		while ($urandom_range(99) < snd_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		pixel_in <= pix;
		drain <= drn;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		crossmorph_step(pix, drn, got, predicted);
		case (chk)
			CHK_MODEL: if (got) pending_px.push_back(predicted);
			CHK_OUT:   pending_px.push_back(typed);
			default:   ;
		endcase
		@(negedge clk);
	endtask

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= LIMIT_CYCLES) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// receiver: one long hold-off once requested, random stalls otherwise
	always @(negedge clk) begin
		if (hold_go && hold_cnt < HOLD_CYCLES) begin
			hold_cnt <= hold_cnt + 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= rcv_pct);
		end
	end

	always @(posedge clk) begin
		px_result_t want;
		if (out_valid && out_ready) begin
			if (pending_px.size() == 0) begin
				$display("%0t: unexpected transfer, expected none, got pixel_out %0d last_pixel %0d",
					$time, pixel_out, last_pixel);
				mismatches++;
			end else begin
				want = pending_px.pop_front();
				if (pixel_out !== want.pix) begin
					$display("%0t: pixel_out expected %0d got %0d", $time, want.pix, pixel_out);
					mismatches++;
				end
				if (last_pixel !== want.last) begin
					$display("%0t: last_pixel expected %0d got %0d", $time, want.last,
						last_pixel);
					mismatches++;
				end
			end
		end
	end

	initial begin
		dir_row_t    dir_tab [N_DIRECTED];
		int unsigned sent, phase, n_frames, n_pix, wv, hv, ew, eh, tv, mv;
		bit          cut, cfg_open;
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = REG_THRESHOLD;
		cfg_data = '0;
		in_valid = 1'b0;
		pixel_in = '0;
		drain = 1'b0;
		sent = 0;
		cfg_open = 1'b0;
		dir_tab = '{
			// size 0 clamps to a one-pixel frame: a result needs two slots past it
			cfg_row(REG_WIDTH, 11'd0),
			cfg_row(REG_HEIGHT, 11'd0),
			item_row(8'hFF, 1'b1, CHK_NONE),
			item_row(8'd128, 1'b0, CHK_NONE),
			item_row(8'd0, 1'b1, CHK_NONE),
			item_row(8'd0, 1'b1, CHK_OUT, PIX_BLACK, 1'b1),
			// pixels past the frame end flush like drains
			cfg_row(REG_OP_MODE, 11'(MODE_UNUSED)),
			cfg_row(REG_THRESHOLD, 11'd255),
			item_row(8'd255, 1'b0, CHK_NONE),
			item_row(8'd0, 1'b0, CHK_NONE),
			item_row(8'd200, 1'b0, CHK_OUT, PIX_BLACK, 1'b1),
			cfg_row(REG_THRESHOLD, 11'd0),
			cfg_row(REG_OP_MODE, 11'(MODE_EXPAND)),
			item_row(8'd1, 1'b0, CHK_NONE),
			item_row(8'd0, 1'b1, CHK_NONE),
			item_row(8'd0, 1'b1, CHK_OUT, PIX_WHITE, 1'b1),
			cfg_row(REG_OP_MODE, 11'(MODE_SHRINK)),
			item_row(8'd0, 1'b0, CHK_NONE),
			item_row(8'd0, 1'b1, CHK_NONE),
			item_row(8'd0, 1'b1, CHK_OUT, PIX_BLACK, 1'b1),
			// 3x2 expand frame with a stray drain and a pixel among the flush
			cfg_row(REG_WIDTH, 11'd3),
			cfg_row(REG_HEIGHT, 11'd2),
			cfg_row(REG_THRESHOLD, 11'd100),
			cfg_row(REG_OP_MODE, 11'(MODE_EXPAND)),
			item_row(8'd255, 1'b0, CHK_MODEL),
			item_row(8'd100, 1'b0, CHK_MODEL),
			item_row(8'd0, 1'b1, CHK_MODEL),
			item_row(8'd101, 1'b0, CHK_MODEL),
			item_row(8'd0, 1'b0, CHK_MODEL),
			item_row(8'd200, 1'b0, CHK_MODEL),
			item_row(8'd101, 1'b0, CHK_MODEL),
			item_row(8'd0, 1'b1, CHK_MODEL),
			item_row(8'd55, 1'b0, CHK_MODEL),
			item_row(8'd0, 1'b1, CHK_MODEL),
			item_row(8'd0, 1'b1, CHK_MODEL)
		};

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_tab[i]) begin
			if (dir_tab[i].kind == ROW_CFG) begin
				if (!cfg_open) begin
					quiesce();
					cfg_open = 1'b1;
				end
				write_reg(dir_tab[i].idx, dir_tab[i].val);
			end else begin
				if (cfg_open) begin
					cfg_write <= 1'b0;
					cfg_open = 1'b0;
				end
				send_item(dir_tab[i].pix, dir_tab[i].drn, dir_tab[i].chk, dir_tab[i].res);
			end
		end

		for (phase = 0; phase < 10 || sent < ITEM_TARGET; phase++) begin
			case (phase % 4)
				0: begin
					snd_pct = 0;
					rcv_pct = 0;
				end
				1: begin
					snd_pct = 62;
					rcv_pct = 0;
				end
				2: begin
					snd_pct = 0;
					rcv_pct = 62;
				end
				default: begin
					snd_pct = 11;
					rcv_pct = 11;
				end
			endcase
			if (phase == 5) begin
				wv = 40;
				hv = 2;
			end else if (phase == 7) begin
				wv = 1;
				hv = 2047;
			end else begin
				wv = ($urandom_range(7) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
				hv = ($urandom_range(7) == 0) ? $urandom_range(12, 7) : $urandom_range(6, 1);
				if ($urandom_range(15) == 0)
					wv = 0;
				if ($urandom_range(15) == 0)
					hv = 0;
			end
			tv = ($urandom_range(4) == 0) ? 255 * $urandom_range(1) : $urandom_range(255);
			mv = $urandom_range(3);
			quiesce();
			write_reg(REG_THRESHOLD, tv);
			write_reg(REG_OP_MODE, mv);
			write_reg(REG_WIDTH, wv);
			write_reg(REG_HEIGHT, hv);
			cfg_write <= 1'b0;
			// hold the output through a wide frame so the input side backs up
			if (phase == 5)
				hold_go = 1'b1;
			ew = clamp_size(wv, MAX_W);
			eh = clamp_size(hv, MAX_H);
			n_frames = (phase == 5 || phase == 7) ? 1 : $urandom_range(3, 1);
			for (int f = 0; f < n_frames; f++) begin
				cut = (f == n_frames - 1) && ($urandom_range(9) == 0);
				n_pix = cut ? $urandom_range(ew * eh - 1) : ew * eh;
				for (int p = 0; p < n_pix; p++) begin
					if ($urandom_range(19) == 0)
						send_item(8'($urandom_range(255)), 1'b1, CHK_MODEL, '0);
					send_item(8'($urandom_range(255)), 1'b0, CHK_MODEL, '0);
					sent++;
				end
				if (!cut) begin
					// flush: width + 1 slots, some carried by stray pixels
					for (int d = 0; d <= ew; d++) begin
						send_item(8'($urandom_range(255)), ($urandom_range(3) != 0),
							CHK_MODEL, '0);
						sent++;
					end
					if ($urandom_range(7) == 0)
						send_item(8'($urandom_range(255)), 1'b1, CHK_MODEL, '0);
				end
			end
		end

		quiesce();
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
